[design/sxp_pkg.sv]
`default_nettype none

package sxp_pkg;

   // MIDI framing bytes.
   localparam logic [7:0] SYSEX_START = 8'hF0;
   localparam logic [7:0] SYSEX_END   = 8'hF7;

   // Number of body bytes kept for command decoding.
   localparam int HEAD_DEPTH = 5;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [2:0] REG_MAKER_ID      = 3'd0;
   localparam logic [2:0] REG_CODE_PITCH    = 3'd1;
   localparam logic [2:0] REG_CODE_VELOCITY = 3'd2;
   localparam logic [2:0] REG_CODE_LENGTH   = 3'd3;
   localparam logic [2:0] REG_CODE_PLAY     = 3'd4;
   localparam logic [2:0] REG_CODE_DUMP_REQ = 3'd5;
   localparam logic [2:0] REG_CODE_DUMP_REP = 3'd6;

   // Register reset values.
   localparam logic [6:0] MAKER_ID_RESET      = 7'd125;
   localparam logic [6:0] CODE_PITCH_RESET    = 7'd1;
   localparam logic [6:0] CODE_VELOCITY_RESET = 7'd2;
   localparam logic [6:0] CODE_LENGTH_RESET   = 7'd3;
   localparam logic [6:0] CODE_PLAY_RESET     = 7'd4;
   localparam logic [6:0] CODE_DUMP_REQ_RESET = 7'd5;
   localparam logic [6:0] CODE_DUMP_REP_RESET = 7'd6;

   // Result kinds.
   localparam logic [2:0] KIND_PITCH    = 3'd0;
   localparam logic [2:0] KIND_VELOCITY = 3'd1;
   localparam logic [2:0] KIND_LENGTH   = 3'd2;
   localparam logic [2:0] KIND_PLAY     = 3'd3;
   localparam logic [2:0] KIND_DUMP     = 3'd4;

   // Positions of the fixed header bytes in a dump.
   localparam int DMP_START    = 0;
   localparam int DMP_MAKER    = 1;
   localparam int DMP_REPLY    = 2;
   localparam int DMP_LENGTH   = 3;
   localparam int DMP_PLAY     = 4;
   localparam int DMP_POSITION = 5;
   localparam int DMP_HEADER   = 6;

   typedef enum logic [2:0] {
      OP_PITCH,
      OP_VELOCITY,
      OP_LENGTH,
      OP_PLAY,
      OP_DUMP
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_APPLY,
      ST_DUMP
   } state_type;

   typedef struct packed {
      logic [6:0] maker_id;
      logic [6:0] code_set_pitch;
      logic [6:0] code_set_velocity;
      logic [6:0] code_set_length;
      logic [6:0] code_set_play;
      logic [6:0] code_dump_request;
      logic [6:0] code_dump_reply;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      op_type     op;
      logic [2:0] step;
      logic [7:0] value;
      logic [2:0] position;
   } cmd_type;

   typedef struct packed {
      logic [6:0] pitch;
      logic [7:0] velocity;
   } step_word_type;

endpackage

`default_nettype wire

[design/sxp_req_if.sv]
`default_nettype none

interface sxp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic [2:0] play_position;

   modport source (output valid, output in_byte, output play_position, input ready);
   modport sink   (input valid, input in_byte, input play_position, output ready);
endinterface

`default_nettype wire

[design/sxp_rsp_if.sv]
`default_nettype none

interface sxp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_kind;
   logic [2:0] step_index;
   logic [7:0] event_value;
   logic       run_end;

   modport source (output valid, output event_kind, output step_index, output event_value,
                   output run_end, input ready);
   modport sink   (input valid, input event_kind, input step_index, input event_value,
                   input run_end, output ready);
endinterface

`default_nettype wire

[design/sysex_command_parser_unit.sv]
// System-exclusive command parser. MIDI bytes arrive one per beat on req_ch; 0xF0 opens a
// message, 0xF7 closes it, and the first five body bytes are kept along with a body count
// (a message longer than BODY_MAX body bytes is dropped). A closed message whose first
// body byte matches maker_id applies one command: set a step's pitch, set a step's velocity
// from two nibbles, set the sequence length (clamped to 1..STEPS), set the play flag, or
// request a dump. Each update yields one beat on rsp_ch; a dump yields 7 + 3*STEPS beats,
// the last one flagged by run_end. Per-step pitch and velocity live in a small synchronous
// memory with a registered read; each entry has a valid bit that reset clears, so the
// memory reads as zero until written and no clearing pass is needed. A byte that causes no
// result only updates the parser; a closing byte that sets the length or play flag goes to
// the apply state, and one that sets a pitch or velocity reads first, then writes back
// through the memory; the apply state waits for a free output register. A dump sends one
// beat per cycle while the consumer takes every beat, paced by the single output register.
// A new byte is accepted whenever the command engine is idle, even while the last result
// still waits in the output register. Registers: APB-style csr_ port, byte address 4*i.

`default_nettype none

module sysex_command_parser_unit #(
   parameter int STEPS    = 8,
   parameter int BODY_MAX = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   sxp_req_if.sink                        req_ch,
   sxp_rsp_if.source                      rsp_ch,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [sxp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [sxp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [sxp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import sxp_pkg::*;

   localparam int AW = $clog2(STEPS);

   cfg_type       cfg;
   cmd_type       cmd;
   logic          engine_ready;
   logic          req_accept;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   logic          wr_en;
   step_word_type rd_word;
   step_word_type wr_word;

   // The parser only ever sees a byte when the engine can take whatever it decodes.
   assign req_ch.ready = engine_ready;
   assign req_accept   = req_ch.valid && engine_ready;

   sxp_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sxp_parser #(
      .STEPS    (STEPS),
      .BODY_MAX (BODY_MAX)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .in_byte       (req_ch.in_byte),
      .play_position (req_ch.play_position),
      .cfg           (cfg),
      .cmd           (cmd)
   );

   sxp_step_mem #(
      .STEPS (STEPS)
   ) u_step_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word)
   );

   sxp_engine #(
      .STEPS (STEPS)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .cmd     (cmd),
      .ready   (engine_ready),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_word (wr_word),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

[design/sxp_csr.sv]
`default_nettype none

module sxp_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [sxp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [sxp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [sxp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output sxp_pkg::cfg_type               cfg
);
   import sxp_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_strobe;
   logic [6:0] wr_value;

   assign pready    = 1'b1;
   assign index     = paddr[CSR_ADDR_W-1:2];
   assign wr_strobe = psel && penable && pwrite;
   assign wr_value  = pwdata[6:0];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_strobe) begin
         case (index)
            REG_MAKER_ID:      cfg_in.maker_id          = wr_value;
            REG_CODE_PITCH:    cfg_in.code_set_pitch    = wr_value;
            REG_CODE_VELOCITY: cfg_in.code_set_velocity = wr_value;
            REG_CODE_LENGTH:   cfg_in.code_set_length   = wr_value;
            REG_CODE_PLAY:     cfg_in.code_set_play     = wr_value;
            REG_CODE_DUMP_REQ: cfg_in.code_dump_request = wr_value;
            REG_CODE_DUMP_REP: cfg_in.code_dump_reply   = wr_value;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_MAKER_ID:      prdata = {25'd0, cfg_ff.maker_id};
         REG_CODE_PITCH:    prdata = {25'd0, cfg_ff.code_set_pitch};
         REG_CODE_VELOCITY: prdata = {25'd0, cfg_ff.code_set_velocity};
         REG_CODE_LENGTH:   prdata = {25'd0, cfg_ff.code_set_length};
         REG_CODE_PLAY:     prdata = {25'd0, cfg_ff.code_set_play};
         REG_CODE_DUMP_REQ: prdata = {25'd0, cfg_ff.code_dump_request};
         REG_CODE_DUMP_REP: prdata = {25'd0, cfg_ff.code_dump_reply};
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.maker_id          <= MAKER_ID_RESET;
         cfg_ff.code_set_pitch    <= CODE_PITCH_RESET;
         cfg_ff.code_set_velocity <= CODE_VELOCITY_RESET;
         cfg_ff.code_set_length   <= CODE_LENGTH_RESET;
         cfg_ff.code_set_play     <= CODE_PLAY_RESET;
         cfg_ff.code_dump_request <= CODE_DUMP_REQ_RESET;
         cfg_ff.code_dump_reply   <= CODE_DUMP_REP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

[design/sxp_parser.sv]
`default_nettype none

module sxp_parser #(
   parameter int STEPS    = 8,
   parameter int BODY_MAX = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   input  logic [2:0]       play_position,
   input  sxp_pkg::cfg_type cfg,
   output sxp_pkg::cmd_type cmd
);
   import sxp_pkg::*;

   localparam int CW = $clog2(BODY_MAX + 1);

   logic          inside_ff;
   logic          inside_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [7:0]    head_ff [HEAD_DEPTH];
   logic          body_beat;

   assign body_beat = accept && inside_ff && (in_byte != SYSEX_START) && (in_byte != SYSEX_END);

   always_comb begin
      inside_in = inside_ff;
      count_in  = count_ff;
      if (accept) begin
         if (in_byte == SYSEX_START) begin
            inside_in = 1'b1;
            count_in  = '0;
         end else if (in_byte == SYSEX_END) begin
            inside_in = 1'b0;
            count_in  = '0;
         end else if (inside_ff) begin
            if (count_ff < CW'(BODY_MAX)) begin
               count_in = count_ff + CW'(1);
            end else begin
               // Overflow drops the message until the next start byte.
               inside_in = 1'b0;
               count_in  = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         inside_ff <= inside_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HEAD_DEPTH; i++) begin
         if (body_beat && (count_ff == CW'(i))) begin
            head_ff[i] <= in_byte;
         end
      end
   end

   // Command decode on the closing byte; the count guards every head entry read.
   always_comb begin
      logic       maker_ok;
      logic       step_ok;
      logic       hit;
      logic [7:0] clamp;
      maker_ok = (count_ff >= CW'(2)) && (head_ff[0] == {1'b0, cfg.maker_id});
      step_ok  = int'(head_ff[2][2:0]) < STEPS;
      hit      = 1'b0;
      if (head_ff[2] == 8'd0) begin
         clamp = 8'd1;
      end else if (head_ff[2] > 8'(STEPS)) begin
         clamp = 8'(STEPS);
      end else begin
         clamp = head_ff[2];
      end
      cmd          = '0;
      cmd.step     = head_ff[2][2:0];
      cmd.position = play_position;
      if (head_ff[1] == {1'b0, cfg.code_set_pitch}) begin
         hit       = (count_ff >= CW'(4)) && step_ok;
         cmd.op    = OP_PITCH;
         cmd.value = {1'b0, head_ff[3][6:0]};
      end else if (head_ff[1] == {1'b0, cfg.code_set_velocity}) begin
         hit       = (count_ff >= CW'(5)) && step_ok;
         cmd.op    = OP_VELOCITY;
         cmd.value = {head_ff[3][3:0], head_ff[4][3:0]};
      end else if (head_ff[1] == {1'b0, cfg.code_set_length}) begin
         hit       = count_ff >= CW'(3);
         cmd.op    = OP_LENGTH;
         cmd.value = {4'd0, clamp[3:0]};
      end else if (head_ff[1] == {1'b0, cfg.code_set_play}) begin
         hit       = count_ff >= CW'(3);
         cmd.op    = OP_PLAY;
         cmd.value = {7'd0, head_ff[2] != 8'd0};
      end else if (head_ff[1] == {1'b0, cfg.code_dump_request}) begin
         hit       = 1'b1;
         cmd.op    = OP_DUMP;
      end
      cmd.valid = accept && (in_byte == SYSEX_END) && inside_ff && maker_ok && hit;
   end

endmodule

`default_nettype wire

[design/sxp_step_mem.sv]
`default_nettype none

module sxp_step_mem #(
   parameter int STEPS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [$clog2(STEPS)-1:0]   rd_addr,
   output sxp_pkg::step_word_type     rd_word,
   input  logic                       wr_en,
   input  logic [$clog2(STEPS)-1:0]   wr_addr,
   input  sxp_pkg::step_word_type     wr_word
);
   import sxp_pkg::*;

   step_word_type    word_ff [STEPS];
   logic [STEPS-1:0] valid_ff;
   step_word_type    rd_word_ff;
   logic             rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         word_ff[wr_addr] <= wr_word;
      end
      rd_word_ff <= word_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written reads as zero.
   assign rd_word = rd_valid_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

[design/sxp_engine.sv]
`default_nettype none

module sxp_engine #(
   parameter int STEPS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sxp_pkg::cfg_type           cfg,
   input  sxp_pkg::cmd_type           cmd,
   output logic                       ready,
   output logic [$clog2(STEPS)-1:0]   rd_addr,
   input  sxp_pkg::step_word_type     rd_word,
   output logic                       wr_en,
   output logic [$clog2(STEPS)-1:0]   wr_addr,
   output sxp_pkg::step_word_type     wr_word,
   sxp_rsp_if.source                  rsp_ch
);
   import sxp_pkg::*;

   localparam int AW         = $clog2(STEPS);
   localparam int DUMP_LEN   = 7 + 3 * STEPS;
   localparam int IW         = $clog2(DUMP_LEN);
   localparam int PITCH_BASE = DMP_HEADER;
   localparam int VEL_BASE   = DMP_HEADER + STEPS;
   localparam int LAST_POS   = DUMP_LEN - 1;

   state_type     state_ff;
   state_type     state_in;
   cmd_type       cmd_ff;
   logic [IW-1:0] idx_ff;
   logic [IW-1:0] idx_in;
   logic [3:0]    length_ff;
   logic [3:0]    length_in;
   logic          play_ff;
   logic          play_in;

   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   logic [2:0]    rsp_kind_ff;
   logic [2:0]    rsp_step_ff;
   logic [7:0]    rsp_value_ff;
   logic          rsp_end_ff;

   logic          out_free;
   logic          emit;
   logic          dump_last;
   logic [2:0]    ev_kind;
   logic [2:0]    ev_step;
   logic [7:0]    ev_value;
   logic          ev_end;
   logic [7:0]    dump_byte;
   logic [IW-1:0] vel_off;

   // Memory entry that holds the data for dump byte k.
   function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] k);
      logic [IW-1:0] off;
      addr_of = '0;
      if (k >= IW'(VEL_BASE) && k < IW'(LAST_POS)) begin
         off     = k - IW'(VEL_BASE);
         addr_of = AW'(off >> 1);
      end else if (k >= IW'(PITCH_BASE) && k < IW'(VEL_BASE)) begin
         off     = k - IW'(PITCH_BASE);
         addr_of = AW'(off);
      end
   endfunction

   assign ready     = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign dump_last = (idx_ff == IW'(LAST_POS));
   assign wr_addr   = AW'(cmd_ff.step);
   assign vel_off   = idx_ff - IW'(VEL_BASE);

   always_comb begin
      if (dump_last) begin
         dump_byte = SYSEX_END;
      end else if (idx_ff >= IW'(VEL_BASE)) begin
         dump_byte = vel_off[0] ? {4'd0, rd_word.velocity[3:0]}
                                : {4'd0, rd_word.velocity[7:4]};
      end else if (idx_ff >= IW'(PITCH_BASE)) begin
         dump_byte = {1'b0, rd_word.pitch};
      end else if (idx_ff == IW'(DMP_START)) begin
         dump_byte = SYSEX_START;
      end else if (idx_ff == IW'(DMP_MAKER)) begin
         dump_byte = {1'b0, cfg.maker_id};
      end else if (idx_ff == IW'(DMP_REPLY)) begin
         dump_byte = {1'b0, cfg.code_dump_reply};
      end else if (idx_ff == IW'(DMP_LENGTH)) begin
         dump_byte = {4'd0, length_ff};
      end else if (idx_ff == IW'(DMP_PLAY)) begin
         dump_byte = {7'd0, play_ff};
      end else if (idx_ff == IW'(DMP_POSITION)) begin
         dump_byte = {5'd0, cmd_ff.position};
      end else begin
         dump_byte = 8'd0;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.valid) begin
               case (cmd.op)
                  OP_PITCH, OP_VELOCITY: state_in = ST_READ;
                  OP_LENGTH, OP_PLAY:    state_in = ST_APPLY;
                  OP_DUMP:               state_in = ST_DUMP;
                  default:               state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ:  state_in = ST_APPLY;
         ST_APPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DUMP: begin
            if (out_free && dump_last) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      emit     = 1'b0;
      wr_en    = 1'b0;
      rd_addr  = '0;
      wr_word  = rd_word;
      ev_kind  = KIND_DUMP;
      ev_step  = 3'd0;
      ev_value = cmd_ff.value;
      ev_end   = 1'b1;
      case (state_ff)
         ST_READ: begin
            rd_addr = AW'(cmd_ff.step);
         end
         ST_APPLY: begin
            rd_addr = AW'(cmd_ff.step);
            emit    = out_free;
            case (cmd_ff.op)
               OP_PITCH: begin
                  ev_kind       = KIND_PITCH;
                  ev_step       = cmd_ff.step;
                  wr_word.pitch = cmd_ff.value[6:0];
                  wr_en         = out_free;
               end
               OP_VELOCITY: begin
                  ev_kind          = KIND_VELOCITY;
                  ev_step          = cmd_ff.step;
                  wr_word.velocity = cmd_ff.value;
                  wr_en            = out_free;
               end
               OP_LENGTH: ev_kind = KIND_LENGTH;
               OP_PLAY:   ev_kind = KIND_PLAY;
               default: ;
            endcase
         end
         ST_DUMP: begin
            emit     = out_free;
            // Look one byte ahead so the read data lines up with the byte sent.
            rd_addr  = addr_of(out_free ? idx_ff + IW'(1) : idx_ff);
            ev_value = dump_byte;
            ev_end   = dump_last;
         end
         default: ;
      endcase
   end

   always_comb begin
      idx_in    = idx_ff;
      length_in = length_ff;
      play_in   = play_ff;
      if (state_ff == ST_IDLE) begin
         idx_in = '0;
      end else if (state_ff == ST_DUMP && out_free) begin
         idx_in = idx_ff + IW'(1);
      end
      if (state_ff == ST_APPLY && emit) begin
         if (cmd_ff.op == OP_LENGTH) begin
            length_in = cmd_ff.value[3:0];
         end
         if (cmd_ff.op == OP_PLAY) begin
            play_in = cmd_ff.value[0];
         end
      end
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ch.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         length_ff    <= 4'(STEPS);
         play_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         length_ff    <= length_in;
         play_ff      <= play_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd.valid) begin
         cmd_ff <= cmd;
      end
      if (emit) begin
         rsp_kind_ff  <= ev_kind;
         rsp_step_ff  <= ev_step;
         rsp_value_ff <= ev_value;
         rsp_end_ff   <= ev_end;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.event_kind  = rsp_kind_ff;
   assign rsp_ch.step_index  = rsp_step_ff;
   assign rsp_ch.event_value = rsp_value_ff;
   assign rsp_ch.run_end     = rsp_end_ff;

`ifndef SYNTHESIS
   a_cmd_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |-> (state_ff == ST_IDLE))
      else $error("command decoded while the engine is busy");

   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && out_free && dump_last) |=> (state_ff == ST_IDLE))
      else $error("dump did not finish after its closing byte");

   a_partial_is_dump: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_end_ff) |-> (rsp_kind_ff == KIND_DUMP))
      else $error("non-final beat on a single-result update");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_APPLY && $past(state_ff) != ST_IDLE))
      else $error("step memory written without a preceding read");
`endif

endmodule

`default_nettype wire
